@@ hdl/bandlm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Band level meter package
// Shared constants, configuration and request types and register clamps.
// ----------------------------------------------------------------------------
package bandlm_pkg;

	localparam int MAX_BANDS       = 64;
	localparam int MAX_BAND_LENGTH = 4096;
	localparam int MAX_CHANNELS    = 8;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 17;
	localparam int SUM_W    = 28;
	localparam int FILL_W   = 13;
	localparam int LEN_W    = 13;
	localparam int CHAN_W   = 4;
	localparam int PHASE_W  = 3;
	localparam int NB_W     = 7;
	localparam int BAND_W   = 6;
	localparam int GAIN_W   = 16;
	localparam int LEVEL_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Product width, and quotient width after the divide by 256 is folded in.
	localparam int PROD_W  = SUM_W + GAIN_W;
	localparam int QUO_W   = PROD_W - 8;
	localparam int REM_W   = 12;
	localparam int CNT_W   = 6;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BANDS_IN_USE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN      = 3'd3;

	// Effective (clamped) configuration.
	typedef struct packed {
		logic [CHAN_W-1:0] chans;
		logic [LEN_W-1:0]  len;
		logic [NB_W-1:0]   nb;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	// Work that one accepted sample asks of the back end.
	typedef struct packed {
		logic              calc;
		logic [SUM_W-1:0]  sum;
		logic [BAND_W-1:0] band;
		logic              fin;
		logic [NB_W-1:0]   next_index;
	} req_t;

	function automatic logic [CHAN_W-1:0] clamp_chans(input logic [CHAN_W-1:0] v);
		logic [CHAN_W-1:0] r;
		r = v;
		if (v == '0) r = CHAN_W'(1);
		else if (v > CHAN_W'(MAX_CHANNELS)) r = CHAN_W'(MAX_CHANNELS);
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0) r = LEN_W'(1);
		else if (v > LEN_W'(MAX_BAND_LENGTH)) r = LEN_W'(MAX_BAND_LENGTH);
		return r;
	endfunction

	function automatic logic [NB_W-1:0] clamp_nb(input logic [NB_W-1:0] v);
		logic [NB_W-1:0] r;
		r = v;
		if (v == '0) r = NB_W'(1);
		else if (v > NB_W'(MAX_BANDS)) r = NB_W'(MAX_BANDS);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/bandlm_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Band level meter sample intake
// Picks channel zero of each frame, accumulates magnitudes per band and
// decides which band, if any, an accepted sample closes.
// ----------------------------------------------------------------------------
module bandlm_accum
	import bandlm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                accept,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last,
	output req_t                     req
);

	logic [PHASE_W-1:0] phase_q;
	logic [SUM_W-1:0]   sum_q;
	logic [FILL_W-1:0]  fill_q;
	logic [NB_W-1:0]    idx_q;

	logic [MAG_W-1:0]   mag;
	logic               take;
	logic [SUM_W-1:0]   sum_a;
	logic [FILL_W-1:0]  fill_t;
	logic [FILL_W-1:0]  fill_a;
	logic               full;
	logic               partial;
	logic [CHAN_W-1:0]  phase_p1;

	always_comb begin
		mag = sample[SAMPLE_W-1] ? (MAG_W'(17'h10000) - {1'b0, sample}) : {1'b0, sample};
		take = (phase_q == '0) && (idx_q < cfg.nb);
		fill_t = fill_q + FILL_W'(1);
		if (take) begin
			sum_a  = sum_q + SUM_W'(mag);
			fill_a = fill_t;
		end else begin
			sum_a  = sum_q;
			fill_a = fill_q;
		end
		full = take && (fill_t >= cfg.len);
		// A buffer that ends inside a band still reports the band it began.
		partial = last && !full && (idx_q < cfg.nb) && (fill_a != '0);
		phase_p1 = CHAN_W'(phase_q) + CHAN_W'(1);

		req.calc       = full || partial;
		req.sum        = sum_a;
		req.band       = idx_q[BAND_W-1:0];
		req.fin        = ((idx_q + NB_W'(1)) == cfg.nb);
		req.next_index = req.calc ? (idx_q + NB_W'(1)) : idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sum_q   <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q <= '0;
				sum_q   <= '0;
				fill_q  <= '0;
				idx_q   <= '0;
			end else begin
				phase_q <= (phase_p1 >= cfg.chans) ? '0 : phase_p1[PHASE_W-1:0];
				if (full) begin
					sum_q  <= '0;
					fill_q <= '0;
					idx_q  <= idx_q + NB_W'(1);
				end else begin
					sum_q  <= sum_a;
					fill_q <= fill_a;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/bandlm_scaler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Band level meter scaler
// Bit-serial shift-add multiply by the gain, then a restoring divide by the
// band length one quotient bit per cycle, then saturation at full scale.
// ----------------------------------------------------------------------------
module bandlm_scaler
	import bandlm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SUM_W-1:0]   sum,
	input  wire logic [GAIN_W-1:0]  gain,
	input  wire logic [LEN_W-1:0]   len,
	input  wire logic               take,
	output logic                    done,
	output logic [LEVEL_W-1:0]      level
);

	typedef enum logic [3:0] {
		SC_IDLE = 4'b0001,
		SC_MUL  = 4'b0010,
		SC_DIV  = 4'b0100,
		SC_DONE = 4'b1000
	} sc_state_t;

	sc_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  w_q;
	logic [SUM_W-1:0]   mcand_q;
	logic [LEN_W-1:0]   len_q;
	logic [REM_W-1:0]   rem_q;

	logic [SUM_W:0]     hi_add;
	logic [PROD_W-1:0]  w_mul;
	logic [REM_W:0]     trial;
	logic               ge;
	logic               sat;

	always_comb begin
		hi_add = {1'b0, w_q[PROD_W-1:GAIN_W]} + (w_q[0] ? {1'b0, mcand_q} : '0);
		w_mul  = {hi_add, w_q[GAIN_W-1:1]};
		trial  = {rem_q, w_q[QUO_W-1]};
		ge     = (trial >= len_q);
		// The quotient exceeds full scale when any bit above 15 is set, or it is
		// 32768 plus something.
		sat    = (w_q[QUO_W-1:LEVEL_W] != '0)
			|| (w_q[LEVEL_W-1] && (w_q[LEVEL_W-2:0] != '0));
		level  = sat ? FULL_SCALE : w_q[LEVEL_W-1:0];
		done   = (state_q == SC_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				SC_IDLE: begin
					if (start) begin
						state_q <= SC_MUL;
						cnt_q   <= CNT_W'(GAIN_W - 1);
					end
				end
				SC_MUL: begin
					if (cnt_q == '0) begin
						state_q <= SC_DIV;
						cnt_q   <= CNT_W'(QUO_W - 1);
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				SC_DIV: begin
					if (cnt_q == '0) state_q <= SC_DONE;
					else cnt_q <= cnt_q - CNT_W'(1);
				end
				SC_DONE: begin
					if (take) state_q <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					w_q     <= {{SUM_W{1'b0}}, gain};
					mcand_q <= sum;
					len_q   <= len;
				end
			end
			SC_MUL: begin
				if (cnt_q == '0) begin
					// Drop the eight fraction bits of the Q8.8 gain here.
					w_q   <= {8'b0, w_mul[PROD_W-1:8]};
					rem_q <= '0;
				end else begin
					w_q <= w_mul;
				end
			end
			SC_DIV: begin
				rem_q <= ge ? REM_W'(trial - REM_W'(len_q)) : trial[REM_W-1:0];
				w_q[QUO_W-1:0] <= {w_q[QUO_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/pcm_band_level_meter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PCM band level meter
// Block-average level meter over interleaved 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Each input transaction carries one interleaved sample; tlast marks the last
// sample of a buffer. A sample that does not close a band and does not end
// the buffer leaves the input ready for the next. A sample that closes a band
// holds off the next sample while the bit-serial scaler runs its 16 multiply
// steps by the gain and 36 restoring divide steps by the band length, and
// longer while the output register still holds an earlier level. At buffer
// end, the bands not yet begun come out as zero levels at one per cycle
// while the output is taken. A result register sits on the output, so the
// next sample is taken while a level still waits there.
// ----------------------------------------------------------------------------
module pcm_band_level_meter_unit
	import bandlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Sample stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] pcm_sample
	input  wire logic        s_tlast,   // buffer_end
	// Band level stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [15:0] band_level, [21:16] band_number
	output logic             m_tlast,   // final_band
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CALC  = 3'b010,
		ST_ZFILL = 3'b100
	} state_t;

	state_t              state_q;
	logic [CHAN_W-1:0]   frame_channels_q;
	logic [LEN_W-1:0]    band_length_q;
	logic [NB_W-1:0]     bands_in_use_q;
	logic [GAIN_W-1:0]   band_gain_q;

	logic [BAND_W-1:0]   band_q;
	logic                fin_q;
	logic                zfill_pend_q;
	logic [NB_W-1:0]     zf_idx_q;

	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic [BAND_W-1:0]   out_band_q;
	logic                out_fin_q;

	cfg_t                cfg;
	req_t                req;
	logic                accept;
	logic                out_free;
	logic                sc_done;
	logic [LEVEL_W-1:0]  sc_level;
	logic                load_lvl;
	logic                load_zero;
	logic                zf_more;

	assign cfg_ready = 1'b1;
	assign cfg.chans = clamp_chans(frame_channels_q);
	assign cfg.len   = clamp_len(band_length_q);
	assign cfg.nb    = clamp_nb(bands_in_use_q);
	assign cfg.gain  = band_gain_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign zf_more   = (zf_idx_q < cfg.nb);
	assign load_lvl  = (state_q == ST_CALC) && sc_done && out_free;
	assign load_zero = (state_q == ST_ZFILL) && zf_more && out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_band_q, out_level_q};
	assign m_tlast  = out_fin_q;

	bandlm_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.sample (s_tdata),
		.last   (s_tlast),
		.req    (req)
	);

	bandlm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && req.calc),
		.sum    (req.sum),
		.gain   (cfg.gain),
		.len    (cfg.len),
		.take   (load_lvl),
		.done   (sc_done),
		.level  (sc_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_channels_q <= CHAN_W'(2);
			band_length_q    <= LEN_W'(16);
			bands_in_use_q   <= NB_W'(32);
			band_gain_q      <= GAIN_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_CHANNELS: frame_channels_q <= cfg_data[CHAN_W-1:0];
				REG_BAND_LENGTH:    band_length_q    <= cfg_data[LEN_W-1:0];
				REG_BANDS_IN_USE:   bands_in_use_q   <= cfg_data[NB_W-1:0];
				REG_BAND_GAIN:      band_gain_q      <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			zfill_pend_q <= 1'b0;
			zf_idx_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						zfill_pend_q <= s_tlast;
						zf_idx_q     <= req.next_index;
						if (req.calc) state_q <= ST_CALC;
						else if (s_tlast) state_q <= ST_ZFILL;
					end
				end
				ST_CALC: begin
					if (load_lvl) state_q <= zfill_pend_q ? ST_ZFILL : ST_IDLE;
				end
				ST_ZFILL: begin
					if (!zf_more) state_q <= ST_IDLE;
					else if (load_zero) zf_idx_q <= zf_idx_q + NB_W'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.calc) begin
			band_q <= req.band;
			fin_q  <= req.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_lvl || load_zero) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_lvl) begin
			out_level_q <= sc_level;
			out_band_q  <= band_q;
			out_fin_q   <= fin_q;
		end else if (load_zero) begin
			out_level_q <= '0;
			out_band_q  <= zf_idx_q[BAND_W-1:0];
			out_fin_q   <= ((zf_idx_q + NB_W'(1)) == cfg.nb);
		end
	end

endmodule
`default_nettype wire
